// File: rtl/gdn_pkg.sv
package gdn_pkg;

   // Field widths of the request and response words.
   localparam int DAY_W  = 5;
   localparam int MON_W  = 4;
   localparam int YEAR_W = 14;
   localparam int OFF_W  = 24;
   localparam int JDN_W  = 23;
   localparam int WKD_W  = 3;

   // Internal widths: signed shifted day number, day count from the March-based
   // epoch, day of era, year of era and day of year.
   localparam int SUM_W  = 26;
   localparam int ZDAY_W = 22;
   localparam int DOE_W  = 18;
   localparam int YOE_W  = 9;
   localparam int DOY_W  = 9;
   localparam int ERA_W  = 5;

   // Pipeline layout. Stage CHK_STG decides the status, the weekday and the
   // date split start at INV_FIRST, and the last stage is the output register.
   localparam int NSTG      = 13;
   localparam int CHK_STG   = 3;
   localparam int INV_FIRST = 4;
   localparam int WKD_STG   = 5;
   localparam int INV_STG   = NSTG - INV_FIRST;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_DATE = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   // Calendar constants.
   localparam int unsigned YEAR_MAX   = 9999;
   localparam int unsigned JDN_FIRST  = 1721426;
   localparam int unsigned JDN_LAST   = 5373484;
   localparam int unsigned MARCH_ZERO = 1721120;  // day number of 1 March, year 0
   localparam int unsigned JDN_BIAS   = 32045;
   localparam int unsigned YEAR_BIAS  = 4800;
   localparam int unsigned CENT_BIAS  = 48;       // YEAR_BIAS / 100
   localparam int unsigned DAYS_ERA   = 146097;
   localparam int unsigned DAYS_4Y    = 1460;
   localparam int unsigned DAYS_CENT  = 36524;
   localparam int unsigned DAYS_YEAR  = 365;
   localparam int unsigned CENT_LEN   = 100;
   localparam int unsigned ERA_YEARS  = 400;

   // Reciprocals for division by a constant: q = (x * C) >> S, exact when
   // divisor * max(x) <= 2**S.
   localparam int R100_S  = 21;
   localparam int R100_CW = 15;
   localparam longint unsigned R100_C = ((64'd1 << R100_S) + 64'd99) / 64'd100;

   localparam int RE_S  = 40;
   localparam int RE_CW = 23;
   localparam longint unsigned RE_C = ((64'd1 << RE_S) + 64'd146096) / 64'd146097;

   localparam int R1460_S  = 29;
   localparam int R1460_CW = 19;
   localparam longint unsigned R1460_C = ((64'd1 << R1460_S) + 64'd1459) / 64'd1460;

   localparam int R365_S  = 27;
   localparam int R365_CW = 19;
   localparam longint unsigned R365_C = ((64'd1 << R365_S) + 64'd364) / 64'd365;

   localparam int R100B_S  = 16;
   localparam int R100B_CW = 10;
   localparam longint unsigned R100B_C = ((64'd1 << R100B_S) + 64'd99) / 64'd100;

   localparam int R153_S  = 20;
   localparam int R153_CW = 13;
   localparam longint unsigned R153_C = ((64'd1 << R153_S) + 64'd152) / 64'd153;

   localparam int R7_S  = 26;
   localparam int R7_CW = 24;
   localparam longint unsigned R7_C = ((64'd1 << R7_S) + 64'd6) / 64'd7;

   // Days before the start of a month in a year that begins on 1 March.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] days;
      case (mp)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// File: rtl/gregorian_day_number_date_shift_unit.sv
// Gregorian date shift unit.
// A request word carries a calendar date (day, month, year) and a signed day
// offset. The response word gives the Julian day number of the date, the date
// that lies the offset away, its weekday (0 Sunday) and a status: ok, invalid
// input date, or shifted date outside the years 1 to 9999. On an invalid date
// all other fields read zero; on a shifted date out of range only the day
// number is kept.
// Both channels use valid/ready; a word moves on a clock edge where both are
// high. A word is accepted at most once per cycle. The unit is a
// thirteen-stage pipeline with a valid bit per stage, so one word per cycle
// is sustained while rsp_ready is high. When the receiver holds rsp_ready
// low, the output word stays and stages behind it keep filling up to the
// first full stage; req_ready drops only once every stage holds a word.
// A synchronous reset empties the pipeline; words in flight are dropped.
module gregorian_day_number_date_shift_unit
   import gdn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [DAY_W-1:0]  req_in_day,
   input  logic [MON_W-1:0]  req_in_month,
   input  logic [YEAR_W-1:0] req_in_year,
   input  logic [OFF_W-1:0]  req_offset_days,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [JDN_W-1:0]  rsp_day_number,
   output logic [DAY_W-1:0]  rsp_out_day,
   output logic [MON_W-1:0]  rsp_out_month,
   output logic [YEAR_W-1:0] rsp_out_year,
   output logic [WKD_W-1:0]  rsp_weekday,
   output logic [1:0]        rsp_status
);

   localparam int CentPW = YEAR_W + R100_CW;
   localparam int WkPW   = JDN_W + R7_CW;

   // Pipeline control: a stage loads when rsp_ready is high or when it or any
   // stage ahead of it up to the output is empty.
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] adv;

   for (genvar g = 0; g < NSTG; g++) begin : g_adv
      assign adv[g] = rsp_ready || !(&vld_ff[NSTG-1:g]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_valid;
         for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[NSTG-1];

   // Stage 0: capture the word and divide the year by 100.
   logic [CentPW-1:0] cent_prod;
   logic [DAY_W-1:0]  d0_ff;
   logic [MON_W-1:0]  m0_ff;
   logic [YEAR_W-1:0] y0_ff;
   logic [OFF_W-1:0]  off0_ff;
   logic [7:0]        q100_0_ff;

   assign cent_prod = CentPW'(req_in_year) * CentPW'(R100_C);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         d0_ff     <= req_in_day;
         m0_ff     <= req_in_month;
         y0_ff     <= req_in_year;
         off0_ff   <= req_offset_days;
         q100_0_ff <= cent_prod[R100_S+7:R100_S];
      end
   end

   // Stage 1: date check and the two halves of the day number sum.
   logic [YEAR_W:0]   cent_y;
   logic              y_exact;
   logic              leap;
   logic [DAY_W-1:0]  mlen;
   logic              date_ok;
   logic              early;
   logic [3:0]        mar_mon;
   logic [YEAR_W:0]   yd;
   logic [7:0]        qd;
   logic              ok1_ff;
   logic [JDN_W:0]    p1_1_ff;
   logic [10:0]       p2_1_ff;
   logic [OFF_W-1:0]  off1_ff;

   assign cent_y  = (YEAR_W+1)'(q100_0_ff) * (YEAR_W+1)'(CENT_LEN);
   assign y_exact = ((YEAR_W+1)'(y0_ff) == cent_y);
   assign leap    = (y0_ff[1:0] == 2'b00) && (!y_exact || q100_0_ff[1:0] == 2'b00);

   always_comb begin
      case (m0_ff) inside
         4'd2:                   mlen = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
         default:                mlen = 5'd31;
      endcase
   end

   assign date_ok = (y0_ff != '0) && (y0_ff <= YEAR_W'(YEAR_MAX))
                 && (m0_ff != '0) && (m0_ff <= 4'd12)
                 && (d0_ff != '0) && (d0_ff <= mlen);

   // January and February count as months 10 and 11 of the previous year.
   assign early   = (m0_ff <= 4'd2);
   assign mar_mon = early ? m0_ff + 4'd9 : m0_ff - 4'd3;
   assign yd      = (YEAR_W+1)'(y0_ff) + (YEAR_W+1)'(YEAR_BIAS) - (YEAR_W+1)'(early);
   assign qd      = q100_0_ff - 8'(early && y_exact) + 8'(CENT_BIAS);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         ok1_ff  <= date_ok;
         p1_1_ff <= (JDN_W+1)'(yd) * (JDN_W+1)'(DAYS_YEAR) + (JDN_W+1)'(yd >> 2)
                  - (JDN_W+1)'(JDN_BIAS);
         p2_1_ff <= 11'(month_start(mar_mon)) + 11'(d0_ff) + 11'(qd >> 2) - 11'(qd);
         off1_ff <= off0_ff;
      end
   end

   // Stage 2: day number of the input date and the shifted day number.
   logic              ok2_ff;
   logic [JDN_W-1:0]  jdn2_ff;
   logic signed [SUM_W-1:0] sum2_ff;
   logic [JDN_W:0]    jdn_sum;

   assign jdn_sum = p1_1_ff + {{(JDN_W-10){p2_1_ff[10]}}, p2_1_ff};

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         ok2_ff  <= ok1_ff;
         jdn2_ff <= jdn_sum[JDN_W-1:0];
         sum2_ff <= $signed({{(SUM_W-JDN_W-1){1'b0}}, jdn_sum})
                  + $signed({{(SUM_W-OFF_W){off1_ff[OFF_W-1]}}, off1_ff});
      end
   end

   // Stage 3: status and the values the date split and weekday start from.
   logic              in_range;
   status_type        st_in;
   logic [JDN_W-1:0]  jdn_ff [CHK_STG:NSTG-1];
   status_type        st_ff  [CHK_STG:NSTG-1];
   logic [ZDAY_W-1:0] z3_ff;
   logic [JDN_W-1:0]  wkx3_ff;

   assign in_range = (sum2_ff >= $signed(SUM_W'(JDN_FIRST)))
                  && (sum2_ff <= $signed(SUM_W'(JDN_LAST)));

   always_comb begin
      if (!ok2_ff)        st_in = STATUS_BAD_DATE;
      else if (!in_range) st_in = STATUS_RANGE;
      else                st_in = STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (adv[CHK_STG]) begin
         jdn_ff[CHK_STG] <= jdn2_ff;
         st_ff[CHK_STG]  <= st_in;
         z3_ff           <= ZDAY_W'(sum2_ff - $signed(SUM_W'(MARCH_ZERO)));
         wkx3_ff         <= JDN_W'(sum2_ff + $signed(SUM_W'(1)));
      end
      for (int k = CHK_STG + 1; k < NSTG; k++) begin
         if (adv[k]) begin
            jdn_ff[k] <= jdn_ff[k-1];
            st_ff[k]  <= st_ff[k-1];
         end
      end
   end

   // Weekday: (day number + 1) mod 7 gives 0 for Sunday.
   logic [WkPW-1:0]  wk_prod;
   logic [JDN_W-1:0] wkx4_ff;
   logic [20:0]      q7_4_ff;
   logic [WKD_W-1:0] wkd_ff [WKD_STG:NSTG-1];

   assign wk_prod = WkPW'(wkx3_ff) * WkPW'(R7_C);

   always_ff @(posedge clock) begin
      if (adv[INV_FIRST]) begin
         wkx4_ff <= wkx3_ff;
         q7_4_ff <= wk_prod[R7_S+20:R7_S];
      end
      if (adv[WKD_STG]) begin
         wkd_ff[WKD_STG] <= WKD_W'(wkx4_ff - JDN_W'(JDN_W'(q7_4_ff) * JDN_W'(7)));
      end
      for (int k = WKD_STG + 1; k < NSTG; k++) begin
         if (adv[k]) wkd_ff[k] <= wkd_ff[k-1];
      end
   end

   // Day number back to a calendar date.
   logic [DAY_W-1:0]  sp_day;
   logic [MON_W-1:0]  sp_month;
   logic [YEAR_W-1:0] sp_year;

   gdn_date_split u_split (
      .clock (clock),
      .adv   (adv[NSTG-1:INV_FIRST]),
      .z     (z3_ff),
      .day   (sp_day),
      .month (sp_month),
      .year  (sp_year)
   );

   // Response word: fields that do not apply to the status read zero.
   logic out_ok;

   assign out_ok         = (st_ff[NSTG-1] == STATUS_OK);
   assign rsp_status     = st_ff[NSTG-1];
   assign rsp_day_number = (st_ff[NSTG-1] == STATUS_BAD_DATE) ? '0 : jdn_ff[NSTG-1];
   assign rsp_out_day    = out_ok ? sp_day : '0;
   assign rsp_out_month  = out_ok ? sp_month : '0;
   assign rsp_out_year   = out_ok ? sp_year : '0;
   assign rsp_weekday    = out_ok ? wkd_ff[NSTG-1] : '0;

endmodule

// File: rtl/gdn_date_split.sv
module gdn_date_split
   import gdn_pkg::*;
(
   input  logic               clock,
   input  logic [INV_STG-1:0] adv,
   input  logic [ZDAY_W-1:0]  z,
   output logic [DAY_W-1:0]   day,
   output logic [MON_W-1:0]   month,
   output logic [YEAR_W-1:0]  year
);

   localparam int EraPW  = ZDAY_W + RE_CW;
   localparam int Q4yPW  = DOE_W + R1460_CW;
   localparam int YoePW  = DOE_W + R365_CW;
   localparam int YqPW   = YOE_W + R100B_CW;
   localparam int NumW   = 12;
   localparam int MpPW   = NumW + R153_CW;

   // Stage 0: era = z / 146097.
   logic [EraPW-1:0]  era_prod;
   logic [ERA_W-1:0]  era0_ff;
   logic [ZDAY_W-1:0] z0_ff;

   assign era_prod = EraPW'(z) * EraPW'(RE_C);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         era0_ff <= era_prod[RE_S+ERA_W-1:RE_S];
         z0_ff   <= z;
      end
   end

   // Stage 1: day of era.
   logic [DOE_W-1:0] doe1_ff;
   logic [ERA_W-1:0] era1_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         doe1_ff <= DOE_W'(z0_ff - ZDAY_W'(ZDAY_W'(era0_ff) * ZDAY_W'(DAYS_ERA)));
         era1_ff <= era0_ff;
      end
   end

   // Stage 2: four-year, century and era corrections of the day of era.
   logic [Q4yPW-1:0] q4y_prod;
   logic [2:0]       cent_cnt;
   logic [7:0]       q4y2_ff;
   logic [2:0]       cent2_ff;
   logic             last2_ff;
   logic [DOE_W-1:0] doe2_ff;
   logic [ERA_W-1:0] era2_ff;

   assign q4y_prod = Q4yPW'(doe1_ff) * Q4yPW'(R1460_C);
   assign cent_cnt = 3'(doe1_ff >= DOE_W'(DAYS_CENT))
                   + 3'(doe1_ff >= DOE_W'(2 * DAYS_CENT))
                   + 3'(doe1_ff >= DOE_W'(3 * DAYS_CENT))
                   + 3'(doe1_ff >= DOE_W'(4 * DAYS_CENT));

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         q4y2_ff  <= q4y_prod[R1460_S+7:R1460_S];
         cent2_ff <= cent_cnt;
         last2_ff <= (doe1_ff == DOE_W'(DAYS_ERA - 1));
         doe2_ff  <= doe1_ff;
         era2_ff  <= era1_ff;
      end
   end

   // Stage 3: numerator of the year-of-era division.
   logic [DOE_W-1:0] ynum3_ff;
   logic [DOE_W-1:0] doe3_ff;
   logic [ERA_W-1:0] era3_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         ynum3_ff <= doe2_ff - DOE_W'(q4y2_ff) + DOE_W'(cent2_ff) - DOE_W'(last2_ff);
         doe3_ff  <= doe2_ff;
         era3_ff  <= era2_ff;
      end
   end

   // Stage 4: year of era.
   logic [YoePW-1:0] yoe_prod;
   logic [YOE_W-1:0] yoe4_ff;
   logic [DOE_W-1:0] doe4_ff;
   logic [ERA_W-1:0] era4_ff;

   assign yoe_prod = YoePW'(ynum3_ff) * YoePW'(R365_C);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         yoe4_ff <= yoe_prod[R365_S+YOE_W-1:R365_S];
         doe4_ff <= doe3_ff;
         era4_ff <= era3_ff;
      end
   end

   // Stage 5: days in the whole years of the era.
   logic [YqPW-1:0]  yq_prod;
   logic [1:0]       yq5_ff;
   logic [DOE_W-1:0] ypart5_ff;
   logic [YOE_W-1:0] yoe5_ff;
   logic [DOE_W-1:0] doe5_ff;
   logic [ERA_W-1:0] era5_ff;

   assign yq_prod = YqPW'(yoe4_ff) * YqPW'(R100B_C);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         yq5_ff    <= yq_prod[R100B_S+1:R100B_S];
         ypart5_ff <= DOE_W'(yoe4_ff) * DOE_W'(DAYS_YEAR) + DOE_W'(yoe4_ff >> 2);
         yoe5_ff   <= yoe4_ff;
         doe5_ff   <= doe4_ff;
         era5_ff   <= era4_ff;
      end
   end

   // Stage 6: day of the March-based year.
   logic [DOY_W-1:0] doy6_ff;
   logic [YOE_W-1:0] yoe6_ff;
   logic [ERA_W-1:0] era6_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         doy6_ff <= DOY_W'(doe5_ff - ypart5_ff + DOE_W'(yq5_ff));
         yoe6_ff <= yoe5_ff;
         era6_ff <= era5_ff;
      end
   end

   // Stage 7: month index counted from March.
   logic [NumW-1:0]  mp_num;
   logic [MpPW-1:0]  mp_prod;
   logic [3:0]       mp7_ff;
   logic [DOY_W-1:0] doy7_ff;
   logic [YOE_W-1:0] yoe7_ff;
   logic [ERA_W-1:0] era7_ff;

   assign mp_num  = NumW'(doy6_ff) * NumW'(5) + NumW'(2);
   assign mp_prod = MpPW'(mp_num) * MpPW'(R153_C);

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         mp7_ff  <= mp_prod[R153_S+3:R153_S];
         doy7_ff <= doy6_ff;
         yoe7_ff <= yoe6_ff;
         era7_ff <= era6_ff;
      end
   end

   // Stage 8: calendar day, month and year. January and February belong to
   // the following calendar year.
   logic early;

   assign early = (mp7_ff >= 4'd10);

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         day   <= DAY_W'(doy7_ff - month_start(mp7_ff) + DOY_W'(1));
         month <= early ? mp7_ff - 4'd9 : mp7_ff + 4'd3;
         year  <= YEAR_W'(yoe7_ff) + YEAR_W'(era7_ff) * YEAR_W'(ERA_YEARS)
                + YEAR_W'(early);
      end
   end

endmodule

// File: rtl/gdn_checker.sv
module gdn_checker
   import gdn_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [DAY_W-1:0]  req_in_day,
   input logic [MON_W-1:0]  req_in_month,
   input logic [YEAR_W-1:0] req_in_year,
   input logic [OFF_W-1:0]  req_offset_days,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [JDN_W-1:0]  rsp_day_number,
   input logic [DAY_W-1:0]  rsp_out_day,
   input logic [MON_W-1:0]  rsp_out_month,
   input logic [YEAR_W-1:0] rsp_out_year,
   input logic [WKD_W-1:0]  rsp_weekday,
   input logic [1:0]        rsp_status
);

   // An invalid input date clears every other field of the word.
   a_bad_date_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD_DATE |->
         rsp_day_number == '0 && rsp_out_day == '0 && rsp_out_month == '0
         && rsp_out_year == '0 && rsp_weekday == '0)
      else $error("invalid date word carries nonzero fields");

   // A shifted date out of range keeps a legal day number and clears the date.
   a_range_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_RANGE |->
         rsp_day_number >= JDN_W'(JDN_FIRST) && rsp_day_number <= JDN_W'(JDN_LAST)
         && rsp_out_day == '0 && rsp_out_month == '0 && rsp_out_year == '0
         && rsp_weekday == '0)
      else $error("out of range word has wrong fields");

   // A good word holds a real calendar date and weekday.
   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
         rsp_out_month != '0 && rsp_out_month <= 4'd12 && rsp_out_day != '0
         && rsp_out_year != '0 && rsp_out_year <= YEAR_W'(YEAR_MAX)
         && rsp_weekday <= 3'd6
         && rsp_day_number >= JDN_W'(JDN_FIRST) && rsp_day_number <= JDN_W'(JDN_LAST))
      else $error("good word holds an impossible date");

   // A stalled response word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_day_number) && $stable(rsp_out_year)
         && $stable(rsp_out_day) && $stable(rsp_status))
      else $error("stalled response word changed");

endmodule

bind gregorian_day_number_date_shift_unit gdn_checker u_gdn_checker (.*);
